[rtl/rau_pkg.sv]
// Shared codes, command and status types for the rational arithmetic unit.
package rau_pkg;

   localparam logic [2:0] OP_ADD  = 3'd0;
   localparam logic [2:0] OP_SUB  = 3'd1;
   localparam logic [2:0] OP_MUL  = 3'd2;
   localparam logic [2:0] OP_DIV  = 3'd3;
   localparam logic [2:0] OP_CMP  = 3'd4;
   localparam logic [2:0] OP_NORM = 3'd5;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_ZDEN = 2'd1,
      ST_DIVZ = 2'd2,
      ST_OVF  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      MS_AN_BD,
      MS_BN_AD,
      MS_AD_BD,
      MS_AN_BN,
      MS_AD_BN
   } mul_sel_type;

   typedef enum logic [1:0] {
      MD_P,
      MD_Q,
      MD_D
   } mul_dst_type;

   typedef enum logic [1:0] {
      FM_ADD,
      FM_SUB,
      FM_P,
      FM_NORM
   } form_type;

   typedef enum logic [1:0] {
      EM_RED,
      EM_ZERO,
      EM_ERR,
      EM_CMP
   } emit_type;

   typedef struct packed {
      logic        load;
      logic        mul_en;
      mul_sel_type mul_sel;
      mul_dst_type mul_dst;
      logic        form_en;
      form_type    form_sel;
      logic        fix_en;
      logic        gcd_step;
      logic        div_load_num;
      logic        div_load_den;
      logic        div_step;
      logic        emit_en;
      emit_type    emit_sel;
      status_type  emit_status;
   } cmd_type;

   typedef struct packed {
      logic a_den_zero;
      logic b_den_zero;
      logic b_num_zero;
      logic rng_ovf;
      logic n_zero;
      logic gcd_done;
   } stat_type;

endpackage

[rtl/rational_arithmetic_unit_top.sv]
// Top level of the rational arithmetic unit: controller, datapath and checks.
//
//  channel   | ports                                   | handshake
//  ----------+-----------------------------------------+------------------------------
//  request   | req_opcode, req_a_num .. req_b_den      | start high while busy low
//  response  | rsp_res_num, rsp_res_den, rsp_cmp_result,| rsp_valid, one cycle, no stall
//            | rsp_status                              |
//
//  The strobe is registered from the check state for a zero denominator or divide by
//  zero, from the third multiply state for compare, from the range check for overflow
//  or a zero numerator, and from the emit state for reduced results, after the binary
//  gcd loop and two 32-step restoring divides on the one shared divider.
//  Synchronous reset returns the controller to idle with no strobe pending.
//  The receiver cannot stall; a new item may start in the cycle of the strobe.
module rational_arithmetic_unit_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_opcode,
   input  logic signed [31:0] req_a_num,
   input  logic signed [31:0] req_a_den,
   input  logic signed [31:0] req_b_num,
   input  logic signed [31:0] req_b_den,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_res_num,
   output logic [30:0]        rsp_res_den,
   output logic signed [1:0]  rsp_cmp_result,
   output logic [1:0]         rsp_status
);
   import rau_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   rau_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_opcode (req_opcode),
      .stat       (stat),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_valid  (rsp_valid)
   );

   rau_dp u_dp (
      .clock          (clock),
      .cmd            (cmd),
      .req_a_num      (req_a_num),
      .req_a_den      (req_a_den),
      .req_b_num      (req_b_num),
      .req_b_den      (req_b_den),
      .stat           (stat),
      .rsp_res_num    (rsp_res_num),
      .rsp_res_den    (rsp_res_den),
      .rsp_cmp_result (rsp_cmp_result),
      .rsp_status     (rsp_status)
   );

   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$past(start && !busy))
      else $error("result strobe directly after an accepted item");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> (rsp_res_num == '0 && rsp_res_den == '0))
      else $error("error result carries a nonzero fraction");

   a_den_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_res_den != '0) |-> (rsp_status == ST_OK && rsp_cmp_result == '0))
      else $error("fraction result with bad status or compare field");

   a_done_strobe: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("controller went idle without a result strobe");

endmodule

[rtl/rau_ctrl.sv]
// Sequencing state machine for the rational arithmetic unit.
module rau_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [2:0]        req_opcode,
   input  rau_pkg::stat_type stat,
   output rau_pkg::cmd_type  cmd,
   output logic              busy,
   output logic              rsp_valid
);
   import rau_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_MUL1,
      S_MUL2,
      S_MUL3,
      S_FORM,
      S_RANGE,
      S_GCD,
      S_DIVN,
      S_LOADD,
      S_DIVD,
      S_EMIT
   } state_type;

   state_type  state_ff, state_in;
   logic [2:0] op_ff, op_in;
   logic [4:0] cnt_ff, cnt_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       is_norm;

   assign is_norm   = (op_ff != OP_ADD) && (op_ff != OP_SUB) && (op_ff != OP_MUL) &&
                      (op_ff != OP_DIV) && (op_ff != OP_CMP);
   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = 1'b0;
      cmd          = '0;
      cmd.mul_sel  = MS_AN_BD;
      cmd.mul_dst  = MD_P;
      cmd.form_sel = FM_P;
      cmd.emit_sel = EM_ERR;
      cmd.emit_status = ST_OK;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               op_in    = req_opcode;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (stat.a_den_zero || (!is_norm && stat.b_den_zero)) begin
               cmd.emit_en     = 1'b1;
               cmd.emit_status = ST_ZDEN;
               rsp_valid_in    = 1'b1;
               state_in        = S_IDLE;
            end else if (op_ff == OP_DIV && stat.b_num_zero) begin
               cmd.emit_en     = 1'b1;
               cmd.emit_status = ST_DIVZ;
               rsp_valid_in    = 1'b1;
               state_in        = S_IDLE;
            end else if (is_norm) begin
               cmd.form_en  = 1'b1;
               cmd.form_sel = FM_NORM;
               state_in     = S_RANGE;
            end else begin
               state_in = S_MUL1;
            end
         end
         S_MUL1: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = (op_ff == OP_MUL) ? MS_AN_BN : MS_AN_BD;
            cmd.mul_dst = MD_P;
            state_in    = S_MUL2;
         end
         S_MUL2: begin
            cmd.mul_en = 1'b1;
            if (op_ff == OP_MUL) begin
               cmd.mul_sel = MS_AD_BD;
               cmd.mul_dst = MD_D;
            end else begin
               cmd.mul_sel = MS_BN_AD;
               cmd.mul_dst = MD_Q;
            end
            state_in = S_MUL3;
         end
         S_MUL3: begin
            if (op_ff == OP_CMP) begin
               cmd.emit_en  = 1'b1;
               cmd.emit_sel = EM_CMP;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               cmd.mul_en  = 1'b1;
               cmd.mul_sel = (op_ff == OP_DIV) ? MS_AD_BN : MS_AD_BD;
               cmd.mul_dst = MD_D;
               state_in    = S_FORM;
            end
         end
         S_FORM: begin
            cmd.form_en = 1'b1;
            if (op_ff == OP_ADD) cmd.form_sel = FM_ADD;
            else if (op_ff == OP_SUB) cmd.form_sel = FM_SUB;
            else cmd.form_sel = FM_P;
            state_in = S_RANGE;
         end
         S_RANGE: begin
            if (stat.rng_ovf) begin
               cmd.emit_en     = 1'b1;
               cmd.emit_status = ST_OVF;
               rsp_valid_in    = 1'b1;
               state_in        = S_IDLE;
            end else if (stat.n_zero) begin
               cmd.emit_en  = 1'b1;
               cmd.emit_sel = EM_ZERO;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               cmd.fix_en = 1'b1;
               state_in   = S_GCD;
            end
         end
         S_GCD: begin
            if (stat.gcd_done) begin
               cmd.div_load_num = 1'b1;
               cnt_in           = '0;
               state_in         = S_DIVN;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         S_DIVN: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 5'd1;
            if (cnt_ff == '1) state_in = S_LOADD;
         end
         S_LOADD: begin
            cmd.div_load_den = 1'b1;
            cnt_in           = '0;
            state_in         = S_DIVD;
         end
         S_DIVD: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 5'd1;
            if (cnt_ff == '1) state_in = S_EMIT;
         end
         S_EMIT: begin
            cmd.emit_en  = 1'b1;
            cmd.emit_sel = EM_RED;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         op_ff        <= OP_ADD;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[rtl/rau_dp.sv]
// Datapath: operand registers, shared multiplier, binary gcd and restoring divider.
module rau_dp (
   input  logic                clock,
   input  rau_pkg::cmd_type    cmd,
   input  logic signed [31:0]  req_a_num,
   input  logic signed [31:0]  req_a_den,
   input  logic signed [31:0]  req_b_num,
   input  logic signed [31:0]  req_b_den,
   output rau_pkg::stat_type   stat,
   output logic signed [31:0]  rsp_res_num,
   output logic [30:0]         rsp_res_den,
   output logic signed [1:0]   rsp_cmp_result,
   output logic [1:0]          rsp_status
);
   import rau_pkg::*;

   logic signed [31:0] a_num_ff, a_den_ff, b_num_ff, b_den_ff;
   logic signed [63:0] p_ff, q_ff, d_ff, n_ff;
   logic signed [31:0] mul_x, mul_y;
   logic signed [63:0] mul_x64, mul_y64, prod;
   logic [31:0]        un_ff, ud_ff;
   logic               neg_ff;
   logic [31:0]        ga_ff, gb_ff, g_ff;
   logic [4:0]         k_ff;
   logic [31:0]        quo_ff, qn_ff, rem_ff;
   logic [32:0]        rem_sh;
   logic               rem_ge;
   logic               n_fits, d_fits;
   logic [31:0]        n_lo, d_lo;
   logic signed [1:0]  cmp_c;
   logic               red_ovf;
   logic signed [31:0] res_num_ff;
   logic [30:0]        res_den_ff;
   logic signed [1:0]  cmp_ff;
   logic [1:0]         status_ff;

   always_comb begin
      case (cmd.mul_sel)
         MS_AN_BD: begin mul_x = a_num_ff; mul_y = b_den_ff; end
         MS_BN_AD: begin mul_x = b_num_ff; mul_y = a_den_ff; end
         MS_AD_BD: begin mul_x = a_den_ff; mul_y = b_den_ff; end
         MS_AN_BN: begin mul_x = a_num_ff; mul_y = b_num_ff; end
         MS_AD_BN: begin mul_x = a_den_ff; mul_y = b_num_ff; end
         default:  begin mul_x = a_num_ff; mul_y = b_den_ff; end
      endcase
   end

   assign mul_x64 = 64'(mul_x);
   assign mul_y64 = 64'(mul_y);
   assign prod    = mul_x64 * mul_y64;

   // value fits in signed 32 bits when bits 63..31 agree
   assign n_fits = (n_ff[63:31] == '0) || (n_ff[63:31] == '1);
   assign d_fits = (d_ff[63:31] == '0) || (d_ff[63:31] == '1);
   assign n_lo   = n_ff[31:0];
   assign d_lo   = d_ff[31:0];

   assign rem_sh = {rem_ff, quo_ff[31]};
   assign rem_ge = (rem_sh >= {1'b0, g_ff});

   always_comb begin
      if (p_ff > q_ff) cmp_c = 2'sd1;
      else if (p_ff < q_ff) cmp_c = -2'sd1;
      else cmp_c = 2'sd0;
      if (a_den_ff[31] ^ b_den_ff[31]) cmp_c = -cmp_c;
   end

   // numerator magnitude may be 2^31 only when the sign is negative
   assign red_ovf = (!neg_ff && qn_ff[31]) || quo_ff[31];

   assign stat.a_den_zero = (a_den_ff == '0);
   assign stat.b_den_zero = (b_den_ff == '0);
   assign stat.b_num_zero = (b_num_ff == '0);
   assign stat.rng_ovf    = !n_fits || !d_fits;
   assign stat.n_zero     = (n_ff == '0);
   assign stat.gcd_done   = (ga_ff == '0) || (gb_ff == '0);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         a_num_ff <= req_a_num;
         a_den_ff <= req_a_den;
         b_num_ff <= req_b_num;
         b_den_ff <= req_b_den;
      end
      if (cmd.mul_en) begin
         case (cmd.mul_dst)
            MD_P:    p_ff <= prod;
            MD_Q:    q_ff <= prod;
            default: d_ff <= prod;
         endcase
      end
      if (cmd.form_en) begin
         case (cmd.form_sel)
            FM_ADD:  n_ff <= p_ff + q_ff;
            FM_SUB:  n_ff <= p_ff - q_ff;
            FM_P:    n_ff <= p_ff;
            default: begin
               n_ff <= 64'(a_num_ff);
               d_ff <= 64'(a_den_ff);
            end
         endcase
      end
      if (cmd.fix_en) begin
         un_ff  <= n_lo[31] ? -n_lo : n_lo;
         ud_ff  <= d_lo[31] ? -d_lo : d_lo;
         ga_ff  <= n_lo[31] ? -n_lo : n_lo;
         gb_ff  <= d_lo[31] ? -d_lo : d_lo;
         neg_ff <= n_lo[31] ^ d_lo[31];
         k_ff   <= '0;
      end
      if (cmd.gcd_step) begin
         if (!ga_ff[0] && !gb_ff[0]) begin
            ga_ff <= ga_ff >> 1;
            gb_ff <= gb_ff >> 1;
            k_ff  <= k_ff + 5'd1;
         end else if (!ga_ff[0]) begin
            ga_ff <= ga_ff >> 1;
         end else if (!gb_ff[0]) begin
            gb_ff <= gb_ff >> 1;
         end else if (ga_ff >= gb_ff) begin
            ga_ff <= ga_ff - gb_ff;
         end else begin
            gb_ff <= gb_ff - ga_ff;
         end
      end
      if (cmd.div_load_num) begin
         g_ff   <= (ga_ff | gb_ff) << k_ff;
         quo_ff <= un_ff;
         rem_ff <= '0;
      end
      if (cmd.div_load_den) begin
         qn_ff  <= quo_ff;
         quo_ff <= ud_ff;
         rem_ff <= '0;
      end
      if (cmd.div_step) begin
         if (rem_ge) begin
            rem_ff <= 32'(rem_sh - {1'b0, g_ff});
            quo_ff <= {quo_ff[30:0], 1'b1};
         end else begin
            rem_ff <= rem_sh[31:0];
            quo_ff <= {quo_ff[30:0], 1'b0};
         end
      end
      if (cmd.emit_en) begin
         case (cmd.emit_sel)
            EM_RED: begin
               if (red_ovf) begin
                  res_num_ff <= '0;
                  res_den_ff <= '0;
                  status_ff  <= ST_OVF;
               end else begin
                  res_num_ff <= neg_ff ? -qn_ff : qn_ff;
                  res_den_ff <= quo_ff[30:0];
                  status_ff  <= ST_OK;
               end
               cmp_ff <= 2'sd0;
            end
            EM_ZERO: begin
               res_num_ff <= '0;
               res_den_ff <= 31'd1;
               cmp_ff     <= 2'sd0;
               status_ff  <= ST_OK;
            end
            EM_CMP: begin
               res_num_ff <= '0;
               res_den_ff <= '0;
               cmp_ff     <= cmp_c;
               status_ff  <= ST_OK;
            end
            default: begin
               res_num_ff <= '0;
               res_den_ff <= '0;
               cmp_ff     <= 2'sd0;
               status_ff  <= cmd.emit_status;
            end
         endcase
      end
   end

   assign rsp_res_num    = res_num_ff;
   assign rsp_res_den    = res_den_ff;
   assign rsp_cmp_result = cmp_ff;
   assign rsp_status     = status_ff;

endmodule
